[hdl/wfea_pkg.sv]
// shared types and constants for the worst fit extent allocator
package wfea_pkg;

    localparam int unsigned AddrBitsDef    = 16;
    localparam int unsigned BusyEntriesDef = 16;
    localparam logic [15:0] MemSizeReset   = 16'd1024;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_NOMATCH = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_SCAN,
        FS_DECIDE,
        FS_SHIFT,
        FS_DONE
    } t_fsm;

    // shift command broadcast down the free chain
    typedef enum logic [1:0] {
        SH_NONE,
        SH_LEFT,
        SH_RIGHT
    } t_shift;

endpackage

[hdl/wfea_cell.sv]
// one free extent cell: holds an extent and shifts to its neighbors
module wfea_cell import wfea_pkg::*; #(
    parameter int unsigned ADDR_BITS = AddrBitsDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_init,
    input  logic                 i_init_valid,
    input  logic [ADDR_BITS-1:0] i_init_len,
    input  t_shift               i_shift,
    input  logic                 i_at_or_after,
    input  logic                 i_is_target,
    input  logic                 i_wr,
    input  logic [ADDR_BITS-1:0] i_wr_start,
    input  logic [ADDR_BITS-1:0] i_wr_len,
    input  logic                 i_left_v,
    input  logic [ADDR_BITS-1:0] i_left_s,
    input  logic [ADDR_BITS-1:0] i_left_l,
    input  logic                 i_right_v,
    input  logic [ADDR_BITS-1:0] i_right_s,
    input  logic [ADDR_BITS-1:0] i_right_l,
    output logic                 o_v,
    output logic [ADDR_BITS-1:0] o_s,
    output logic [ADDR_BITS-1:0] o_l
);

    logic                 r_v, n_v;
    logic [ADDR_BITS-1:0] r_s, n_s, r_l, n_l;

    always_comb begin
        n_v = r_v;
        n_s = r_s;
        n_l = r_l;
        if (i_init) begin
            n_v = i_init_valid;
            n_s = '0;
            n_l = i_init_len;
        end else if (i_is_target && i_wr) begin
            n_v = 1'b1;
            n_s = i_wr_start;
            n_l = i_wr_len;
        end else if (i_shift == SH_LEFT && i_at_or_after) begin
            n_v = i_right_v;
            n_s = i_right_s;
            n_l = i_right_l;
        end else if (i_shift == SH_RIGHT && i_at_or_after) begin
            n_v = i_left_v;
            n_s = i_left_s;
            n_l = i_left_l;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= n_v;
        end
        r_s <= n_s;
        r_l <= n_l;
    end

    assign o_v = r_v;
    assign o_s = r_s;
    assign o_l = r_l;

endmodule

[hdl/worst_fit_extent_allocator_unit.sv]
// top level: worst fit extent allocator with coalescing free chain
//
// channel | signals                                   | dir
// request | i_valid o_ready i_req_type/size/addr      | in
// result  | o_valid i_ready o_status o_alloc_addr     | out
// config  | i_cfg_we i_cfg_data                       | in
//
// a taken request passes through the scan, decide and shift states:
// the scan state walks the free chain and busy table in parallel,
// then the decide state picks the action and the shift state applies it to the chain
// the result is valid after the shift state; a done state follows before idle
// reset and a nonzero mem_size write leave one free extent at zero; ready is low one cycle
// a result waits in the output register; the next request is taken once it leaves
module worst_fit_extent_allocator_unit import wfea_pkg::*; #(
    parameter int unsigned ADDR_BITS    = AddrBitsDef,
    parameter int unsigned BUSY_ENTRIES = BusyEntriesDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_req_type,
    input  logic [15:0]          i_req_size,
    input  logic [15:0]          i_req_addr,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_status,
    output logic [15:0]          o_alloc_addr,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_data
);

    localparam int unsigned FreeN = BUSY_ENTRIES + 1;
    localparam int unsigned FI    = $clog2(FreeN + 1);
    localparam int unsigned BI    = $clog2(BUSY_ENTRIES);
    localparam int unsigned AW    = ADDR_BITS;
    localparam int unsigned CW    = (FI > BI ? FI : BI) + 1;

    t_fsm r_st, n_st;

    logic          r_type;
    logic [AW:0]   r_size;
    logic [AW-1:0] r_addr;
    logic          r_aovf;
    logic [CW-1:0] r_cnt;
    logic          r_init;
    logic [15:0]   r_msize;

    // free chain
    logic          c_v [FreeN];
    logic [AW-1:0] c_s [FreeN];
    logic [AW-1:0] c_l [FreeN];
    t_shift        w_shift;
    logic [FI-1:0] w_pos;
    logic          w_wr;
    logic [AW-1:0] w_wr_s, w_wr_l;

    // scan results
    logic          r_bfound;
    logic [FI-1:0] r_best;
    logic [AW-1:0] r_best_l, r_best_s;
    logic [FI-1:0] r_p;
    logic          r_pfound;
    logic [FI-1:0] r_fcount;

    // busy table
    logic [AW-1:0] r_bs [BUSY_ENTRIES];
    logic [AW-1:0] r_bl [BUSY_ENTRIES];
    logic [BUSY_ENTRIES-1:0] r_bv;
    logic          r_slot_f, r_hit_f;
    logic [BI-1:0] r_slot, r_hit;

    logic [1:0]    r_ostat;
    logic [15:0]   r_oaddr;
    logic          r_ovalid;

    logic [AW-1:0] w_init_len;
    logic          w_init_valid;
    logic [AW-1:0] w_req_size_a, w_req_addr_a;

    assign w_init_len   = (r_msize > 16'(({AW{1'b1}}) & 16'hFFFF) && AW < 16)
                          ? {AW{1'b1}} : AW'(r_msize);
    assign w_init_valid = (r_msize != 16'd0);
    assign w_req_size_a = AW'(i_req_size);
    assign w_req_addr_a = AW'(i_req_addr);

    // cell chain
    genvar g;
    generate
        for (g = 0; g < FreeN; g++) begin : g_cell
            logic          lv, rv;
            logic [AW-1:0] ls, ll, rs, rl;
            if (g == 0) begin : g_l0
                assign lv = 1'b0; assign ls = '0; assign ll = '0;
            end else begin : g_ln
                assign lv = c_v[g-1]; assign ls = c_s[g-1]; assign ll = c_l[g-1];
            end
            if (g == FreeN - 1) begin : g_r0
                assign rv = 1'b0; assign rs = '0; assign rl = '0;
            end else begin : g_rn
                assign rv = c_v[g+1]; assign rs = c_s[g+1]; assign rl = c_l[g+1];
            end
            wfea_cell #(.ADDR_BITS(AW)) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_init       (r_init),
                .i_init_valid (g == 0 ? w_init_valid : 1'b0),
                .i_init_len   (g == 0 ? w_init_len : '0),
                .i_shift      (w_shift),
                .i_at_or_after((FI'(g) >= w_pos && !(w_shift == SH_RIGHT && FI'(g) == w_pos))
                               || (w_shift == SH_RIGHT && FI'(g) > w_pos)),
                .i_is_target  (FI'(g) == w_pos),
                .i_wr         (w_wr),
                .i_wr_start   (w_wr_s),
                .i_wr_len     (w_wr_l),
                .i_left_v     (lv), .i_left_s(ls), .i_left_l(ll),
                .i_right_v    (rv), .i_right_s(rs), .i_right_l(rl),
                .o_v          (c_v[g]),
                .o_s          (c_s[g]),
                .o_l          (c_l[g])
            );
        end
    endgenerate

    assign o_ready      = (r_st == FS_IDLE) && !r_ovalid && !r_init;
    assign o_valid      = r_ovalid;
    assign o_status     = r_ostat;
    assign o_alloc_addr = r_oaddr;

    // scan index selections
    logic [FI-1:0] w_fi;
    logic [BI-1:0] w_bi;
    logic          w_fin, w_bin;
    assign w_fi  = r_cnt[FI-1:0];
    assign w_bi  = r_cnt[BI-1:0];
    assign w_fin = (r_cnt < CW'(FreeN));
    assign w_bin = (r_cnt < CW'(BUSY_ENTRIES));

    logic [FI-1:0] w_pm1;
    assign w_pm1 = r_p - FI'(1);

    // decide-stage values (read from chain at one or two positions)
    logic          d_prev_v, d_next_v, jp, jn;
    logic [AW-1:0] d_prev_s, d_prev_l, d_next_s, d_next_l;
    assign d_prev_v = (r_p != '0) && c_v[w_pm1];
    assign d_prev_s = c_s[w_pm1];
    assign d_prev_l = c_l[w_pm1];
    assign d_next_v = r_pfound;
    assign d_next_s = c_s[r_p];
    assign d_next_l = c_l[r_p];
    assign jp = d_prev_v && ({1'b0, d_prev_s} + {1'b0, d_prev_l} == {1'b0, r_addr});
    assign jn = d_next_v && ({1'b0, r_addr} + r_size == {1'b0, d_next_s});

    // decide-stage actions held for the shift cycle
    t_shift        r_shift;
    logic          r_wr;
    logic [AW-1:0] r_wr_s, r_wr_l;
    logic [FI-1:0] r_wpos;

    always_comb begin
        w_shift = SH_NONE;
        w_wr    = 1'b0;
        w_wr_s  = r_wr_s;
        w_wr_l  = r_wr_l;
        w_pos   = r_wpos;
        if (r_st == FS_SHIFT) begin
            w_shift = r_shift;
            w_wr    = r_wr;
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            FS_IDLE:   if (i_valid && o_ready) n_st = FS_SCAN;
            FS_SCAN:   if (!w_fin && !w_bin) n_st = FS_DECIDE;
            FS_DECIDE: n_st = FS_SHIFT;
            FS_SHIFT:  n_st = FS_DONE;
            FS_DONE:   n_st = FS_IDLE;
            default:   n_st = FS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= FS_IDLE;
            r_ovalid <= 1'b0;
            r_init   <= 1'b1;
            r_msize  <= MemSizeReset;
            r_bv     <= '0;
            r_shift  <= SH_NONE;
            r_wr     <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_init <= i_cfg_we;
            if (o_valid && i_ready) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                r_msize <= i_cfg_data;
                r_bv    <= '0;
            end
            unique case (r_st)
                FS_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_type   <= i_req_type;
                        r_size   <= {1'b0, w_req_size_a} |
                                    ((AW < 16 && (i_req_size >> AW) != 0) ?
                                     {1'b1, {AW{1'b0}}} : '0);
                        r_addr   <= w_req_addr_a;
                        r_aovf   <= (AW < 16) && ((i_req_addr >> AW) != 0);
                        r_cnt    <= '0;
                        r_bfound <= 1'b0;
                        r_pfound <= 1'b0;
                        r_p      <= '0;
                        r_fcount <= '0;
                        r_slot_f <= 1'b0;
                        r_hit_f  <= 1'b0;
                        r_best   <= '0;
                        r_best_l <= '0;
                        r_best_s <= '0;
                    end
                end
                FS_SCAN: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (w_fin && c_v[w_fi]) begin
                        r_fcount <= w_fi + FI'(1);
                        if (!r_bfound || c_l[w_fi] >= r_best_l) begin
                            r_bfound <= 1'b1;
                            r_best   <= w_fi;
                            r_best_l <= c_l[w_fi];
                            r_best_s <= c_s[w_fi];
                        end
                        if (!r_pfound && !(c_s[w_fi] < r_addr)) begin
                            r_pfound <= 1'b1;
                            r_p      <= w_fi;
                        end else if (!r_pfound) begin
                            r_p <= w_fi + FI'(1);
                        end
                    end
                    if (w_bin) begin
                        if (!r_bv[w_bi] && !r_slot_f) begin
                            r_slot_f <= 1'b1;
                            r_slot   <= w_bi;
                        end
                        if (r_bv[w_bi] && !r_hit_f && !r_aovf && r_bs[w_bi] == r_addr &&
                            {1'b0, r_bl[w_bi]} == r_size) begin
                            r_hit_f <= 1'b1;
                            r_hit   <= w_bi;
                        end
                    end
                end
                FS_DECIDE: begin
                    r_shift  <= SH_NONE;
                    r_wr     <= 1'b0;
                    r_oaddr  <= '0;
                    r_ostat  <= ST_OK;
                    if (r_type == REQ_ALLOC) begin
                        if (r_size == '0 || !r_bfound || {1'b0, r_best_l} < r_size) begin
                            r_ostat <= ST_NOFIT;
                        end else if (!r_slot_f) begin
                            r_ostat <= ST_FULL;
                        end else begin
                            r_oaddr <= 16'(r_best_s);
                            r_bv[r_slot] <= 1'b1;
                            r_bs[r_slot] <= r_best_s;
                            r_bl[r_slot] <= r_size[AW-1:0];
                            r_wpos <= r_best;
                            if (r_best_l == r_size[AW-1:0]) begin
                                r_shift <= SH_LEFT;
                            end else begin
                                r_wr   <= 1'b1;
                                r_wr_s <= r_best_s + r_size[AW-1:0];
                                r_wr_l <= r_best_l - r_size[AW-1:0];
                            end
                        end
                    end else begin
                        if (!r_hit_f) begin
                            r_ostat <= ST_NOMATCH;
                        end else begin
                            r_bv[r_hit] <= 1'b0;
                            if (jp && jn) begin
                                r_wpos  <= w_pm1;
                                r_wr    <= 1'b1;
                                r_wr_s  <= d_prev_s;
                                r_wr_l  <= d_prev_l + r_size[AW-1:0] + d_next_l;
                                r_shift <= SH_LEFT;
                            end else if (jp) begin
                                r_wpos <= w_pm1;
                                r_wr   <= 1'b1;
                                r_wr_s <= d_prev_s;
                                r_wr_l <= d_prev_l + r_size[AW-1:0];
                            end else if (jn) begin
                                r_wpos <= r_p;
                                r_wr   <= 1'b1;
                                r_wr_s <= r_addr;
                                r_wr_l <= d_next_l + r_size[AW-1:0];
                            end else if (r_fcount < FI'(FreeN)) begin
                                r_wpos  <= r_p;
                                r_wr    <= 1'b1;
                                r_wr_s  <= r_addr;
                                r_wr_l  <= r_size[AW-1:0];
                                r_shift <= SH_RIGHT;
                            end
                        end
                    end
                end
                FS_SHIFT: begin
                    r_ovalid <= 1'b1;
                end
                FS_DONE: ;
                default: ;
            endcase
        end
    end

endmodule
